[rtl/thtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter package
// Shared types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package thtc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int RES_W      = 20;
  localparam int BASE_W     = 14;
  localparam int BETA0_W    = 14;
  localparam int BETA_W     = 16;
  localparam int LIM_W      = 12;
  localparam int TEMP_W     = 16;
  localparam int T0C_W      = 16;
  localparam int T0C_HI_W   = 9;
  localparam int T0C_LO_W   = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_SIDE = 3'd0,
    REG_SERIES    = 3'd1,
    REG_NOMINAL   = 3'd2,
    REG_BASE_TEMP = 3'd3,
    REG_BETA0     = 3'd4,
    REG_RANGE1    = 3'd5,
    REG_RANGE2    = 3'd6
  } thtc_reg_t;

  localparam logic [RES_W-1:0]      RS_RST    = 20'd10000;
  localparam logic [RES_W-1:0]      R0_RST    = 20'd10000;
  localparam logic [BASE_W-1:0]     BASE_RST  = 14'd2500;
  localparam logic [BETA0_W-1:0]    BETA0_RST = 14'd3435;

  localparam logic signed [TEMP_W-1:0] T_MAX_C  = 16'sd30000;
  localparam logic signed [TEMP_W-1:0] T_MIN_C  = -16'sd5500;
  localparam logic [T0C_W-1:0]         KELVIN_C = 16'd27315;
  localparam logic [T0C_W-1:0]         TK_MAX_C = 16'd57315;

  // pipeline depths
  localparam int LOG_LAT = 3;
  localparam int LN_LAT  = 8;
  localparam int QUO_W   = 16;

  // datapath widths
  localparam int L24_W = 30;
  localparam int C_W   = 23;
  localparam int Q_W   = 40;
  localparam int D_W   = 42;
  localparam int QD_W  = 41;
  localparam int QN_W  = 57;

  localparam logic [15:0] LN2_Q16      = 16'd45426;
  localparam logic [8:0]  LN_RND       = 9'd128;
  localparam logic [6:0]  HUNDRED      = 7'd100;
  localparam logic [29:0] RECIP100_36  = 30'd687194768;
  localparam int          RECIP36_S    = 36;
  localparam logic [16:0] RECIP100_23  = 17'd83887;
  localparam int          RECIP23_S    = 23;
  localparam logic [13:0] RECIP100_20  = 14'd10486;
  localparam int          RECIP20_S    = 20;

  typedef struct packed {
    logic              vld;
    logic              hot;
    logic              cold;
    logic              over;
    logic [BETA_W-1:0] beta;
  } thtc_meta_t;

  // log2(1 + k/16) in Q16
  function automatic logic [16:0] log_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/thtc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter input channel
// Valid/ready stream carrying one ADC code per word.
// ----------------------------------------------------------------------------
interface thtc_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

[rtl/thtc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter result channel
// Valid/ready stream carrying one temperature per word.
// ----------------------------------------------------------------------------
interface thtc_out_if
  import thtc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic                     out_of_range;

  modport source (output valid, output temp_centi, output out_of_range, input ready);
  modport sink   (input valid, input temp_centi, input out_of_range, output ready);
endinterface

[rtl/thtc_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter configuration channel
// Register write port: index and data per word.
// ----------------------------------------------------------------------------
interface thtc_cfg_if
  import thtc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/thtc_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter log2 pipeline
// Leading-one search, normalise, table lookup with linear interpolation (Q16).
// ----------------------------------------------------------------------------
module thtc_log2
  import thtc_pkg::*;
#(
  parameter int W  = 32,
  parameter int LW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  x,
  output logic [LW-1:0] y
);

  localparam int PW = $clog2(W);

  logic [PW-1:0] p_nxt;
  logic [PW-1:0] p1_r;
  logic [W-1:0]  x1_r;

  logic [PW-1:0] sh_s;
  logic [W-1:0]  norm_s;
  logic [PW-1:0] p2_r;
  logic [3:0]    idx2_r;
  logic [15:0]   rem2_r;

  logic [16:0]   tab0_s;
  logic [16:0]   tab1_s;
  logic [16:0]   step_s;
  logic [32:0]   prod_s;
  logic [LW-1:0] y_nxt;
  logic [LW-1:0] y_r;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) begin
        p_nxt = PW'(i);
      end
    end
  end

  assign sh_s   = PW'(W - 1) - p1_r;
  assign norm_s = x1_r << sh_s;

  assign tab0_s = log_tab({1'b0, idx2_r});
  assign tab1_s = log_tab({1'b0, idx2_r} + 5'd1);
  assign step_s = tab1_s - tab0_s;
  assign prod_s = step_s * rem2_r;
  assign y_nxt  = {p2_r, 16'b0} + tab0_s + prod_s[32:16];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p_nxt;
      x1_r   <= x;
      p2_r   <= p1_r;
      idx2_r <= norm_s[W-2 -: 4];
      rem2_r <= norm_s[W-6 -: 16];
      y_r    <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[rtl/thtc_lnscale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter log scaling pipeline
// Forms ln(R/R0) in Q24, scales by T0/100 and builds the divider operands.
// ----------------------------------------------------------------------------
module thtc_lnscale
  import thtc_pkg::*;
#(
  parameter int LW = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  thtc_meta_t          meta_i,
  input  logic [LW-1:0]       log_n,
  input  logic [LW-1:0]       log_d,
  input  logic [T0C_W-1:0]    t0c,
  input  logic [T0C_HI_W-1:0] t0c_hi,
  input  logic [T0C_LO_W-1:0] t0c_lo,
  output thtc_meta_t          meta_o,
  output logic [QN_W-1:0]     quo_num,
  output logic [QD_W-1:0]     quo_den
);

  thtc_meta_t meta_r [LN_LAT];
  logic       neg_r  [6];

  logic [LW:0]             diff_s;
  logic [LW:0]             ndiff_s;
  logic [LW-1:0]           mag1_r;
  logic [LW+15:0]          ln_prod_s;
  logic [L24_W-1:0]        l24_2_r;
  logic [L24_W+29:0]       c_prod_s;
  logic [L24_W-1:0]        l24_3_r;
  logic [C_W-1:0]          c3_r;
  logic [L24_W-1:0]        hund_s;
  logic [L24_W-1:0]        erem_s;
  logic [C_W-1:0]          c4_r;
  logic [T0C_LO_W-1:0]     e4_r;
  logic [C_W+T0C_W-1:0]    x1_r;
  logic [T0C_HI_W+6:0]     x2_r;
  logic [13:0]             x3_r;
  logic [27:0]             q3_prod_s;
  logic [Q_W-1:0]          q_s;
  logic [Q_W-1:0]          q6_r;
  logic [D_W-1:0]          bsh_s;
  logic [D_W-1:0]          q_ext_s;
  logic [D_W-1:0]          d7_r;
  logic [31:0]             nu_s;
  logic [31:0]             nu7_r;
  logic                    dpos_s;
  logic [QN_W-1:0]         n_s;
  logic [QN_W-1:0]         num8_r;
  logic [QD_W-1:0]         den8_r;
  thtc_meta_t              meta8_s;

  assign diff_s    = {1'b0, log_n} - {1'b0, log_d};
  assign ndiff_s   = -diff_s;
  assign ln_prod_s = mag1_r * LN2_Q16 + LN_RND;
  assign c_prod_s  = l24_2_r * RECIP100_36;
  assign hund_s    = c3_r * HUNDRED;
  assign erem_s    = l24_3_r - hund_s;
  assign q3_prod_s = x3_r * RECIP100_20;
  assign q_s       = x1_r + x2_r + q3_prod_s[RECIP20_S+6:RECIP20_S];
  assign bsh_s     = {2'b00, meta_r[5].beta, 24'b0};
  assign q_ext_s   = {2'b00, q6_r};
  assign nu_s      = meta_r[5].beta * t0c;
  assign dpos_s    = !d7_r[D_W-1] && (d7_r != '0);
  assign n_s       = {1'b0, nu7_r, 24'b0} + {17'b0, d7_r[QD_W-1:1]};

  always_comb begin
    meta8_s      = meta_r[6];
    meta8_s.hot  = meta_r[6].hot || (!meta_r[6].cold && !dpos_s);
    meta8_s.over = n_s >= {d7_r[QD_W-1:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LN_LAT; k++) begin
        meta_r[k] <= '0;
      end
    end else if (en) begin
      meta_r[0] <= meta_i;
      for (int k = 1; k < LN_LAT - 1; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
      meta_r[LN_LAT-1] <= meta8_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= diff_s[LW];
      for (int k = 1; k < 6; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
      mag1_r  <= diff_s[LW] ? ndiff_s[LW-1:0] : diff_s[LW-1:0];
      l24_2_r <= ln_prod_s[L24_W+7:8];
      l24_3_r <= l24_2_r;
      c3_r    <= c_prod_s[RECIP36_S+C_W-1:RECIP36_S];
      c4_r    <= c3_r;
      e4_r    <= erem_s[T0C_LO_W-1:0];
      x1_r    <= c4_r * t0c;
      x2_r    <= t0c_hi * e4_r;
      x3_r    <= e4_r * t0c_lo;
      q6_r    <= q_s;
      d7_r    <= neg_r[5] ? (bsh_s - q_ext_s) : (bsh_s + q_ext_s);
      nu7_r   <= nu_s;
      num8_r  <= n_s;
      den8_r  <= d7_r[QD_W-1:0];
    end
  end

  assign meta_o  = meta_r[LN_LAT-1];
  assign quo_num = num8_r;
  assign quo_den = den8_r;

endmodule

[rtl/thtc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter divider pipeline
// Restoring division, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module thtc_div
  import thtc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  thtc_meta_t       meta_i,
  input  logic [QN_W-1:0]  num_i,
  input  logic [QD_W-1:0]  den_i,
  output thtc_meta_t       meta_o,
  output logic [QUO_W-1:0] quo_o
);

  thtc_meta_t       meta_r [QUO_W];
  logic [QN_W-1:0]  rem_r  [QUO_W];
  logic [QD_W-1:0]  den_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    thtc_meta_t       meta_in;
    logic [QN_W-1:0]  rem_in;
    logic [QD_W-1:0]  den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QN_W-1:0]  dsh_s;
    logic             ge_s;
    logic [QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign meta_in = meta_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign meta_in = meta_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
    end

    assign dsh_s = {{(QN_W-QD_W){1'b0}}, den_in} << BIT;
    assign ge_s  = rem_in >= dsh_s;

    always_comb begin
      quo_nxt      = quo_in;
      quo_nxt[BIT] = ge_s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[k] <= '0;
      end else if (en) begin
        meta_r[k] <= meta_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge_s ? (rem_in - dsh_s) : rem_in;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign meta_o = meta_r[QUO_W-1];
  assign quo_o  = quo_r[QUO_W-1];

endmodule

[rtl/thermistor_adc_to_temperature_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature converter
// Divider ADC code to temperature in 1/100 degC via the beta equation.
//
//   channel  dir  fields                          accepted when
//   in_ch    in   adc_code                        valid && ready
//   out_ch   out  temp_centi, out_of_range        valid && ready
//   cfg_ch   in   index, wdata                    valid && ready (always ready)
//
// One word enters per cycle while the pipeline is not held. An accepted word
// passes the input stage, 3 log2 stages, 8 scaling stages, 16 divider stages
// and the output stage. The 16-stage restoring divider sets the depth.
// Reset is synchronous, clears valid bits and presets config registers only.
// A stalled output word moves to a skid register; input ready drops while it
// is full and the whole pipeline holds.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_core
  import thtc_pkg::*;
#(
  parameter int ADC_BITS    = 12,
  parameter int BETA_RANGES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  thtc_in_if.sink    in_ch,
  thtc_out_if.source out_ch,
  thtc_cfg_if.sink   cfg_ch
);

  localparam int N_W    = ADC_BITS + 1;
  localparam int NUM_W  = RES_W + ADC_BITS;
  localparam int LOG_W  = $clog2(NUM_W) + 17;
  localparam int CMP_W  = ADC_BITS + LIM_W + 1;
  localparam logic [N_W-1:0] FULL_N = N_W'(1) << ADC_BITS;

  // configuration registers
  logic                  high_r;
  logic [RES_W-1:0]      rs_r;
  logic [RES_W-1:0]      r0_r;
  logic [BASE_W-1:0]     base_r;
  logic [BETA0_W-1:0]    beta0_r;
  logic [CFG_DATA_W-1:0] rng1_r;
  logic [CFG_DATA_W-1:0] rng2_r;

  logic [T0C_W-1:0]      t0c_r;
  logic [T0C_HI_W-1:0]   t0c_hi_r;
  logic [T0C_LO_W-1:0]   t0c_lo_r;
  logic [T0C_W+16:0]     hi_prod_s;
  logic [T0C_W-1:0]      hi100_s;
  logic [T0C_W-1:0]      lo_s;

  logic                  en;

  logic [N_W-1:0]        code_n;
  logic [N_W-1:0]        n_s;
  logic [N_W-1:0]        nc_s;
  logic [BETA_W-1:0]     beta_s;
  logic [CFG_DATA_W-1:0] rng_word;
  logic [CMP_W-1:0]      lhs_s;
  logic [CMP_W-1:0]      rhs_s;
  logic [RES_W+N_W-1:0]  num_full;
  logic [RES_W+N_W-1:0]  den_full;
  logic                  hot0_s;
  logic                  cold0_s;

  thtc_meta_t            meta0_r;
  logic [NUM_W-1:0]      num0_r;
  logic [NUM_W-1:0]      den0_r;
  thtc_meta_t            meta_lg_r [LOG_LAT];
  logic [LOG_W-1:0]      log_n;
  logic [LOG_W-1:0]      log_d;

  thtc_meta_t            ln_meta;
  logic [QN_W-1:0]       ln_num;
  logic [QD_W-1:0]       ln_den;
  thtc_meta_t            dv_meta;
  logic [QUO_W-1:0]      dv_quo;

  logic signed [16:0]        tc_s;
  logic signed [TEMP_W-1:0]  fin_temp_s;
  logic                      fin_oor_s;
  logic                      pv_r;
  logic signed [TEMP_W-1:0]  fin_temp_r;
  logic                      fin_oor_r;
  logic                      sv_r;
  logic signed [TEMP_W-1:0]  sk_temp_r;
  logic                      sk_oor_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= 1'b0;
      rs_r    <= RS_RST;
      r0_r    <= R0_RST;
      base_r  <= BASE_RST;
      beta0_r <= BETA0_RST;
      rng1_r  <= '0;
      rng2_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HIGH_SIDE: high_r  <= cfg_ch.wdata[0];
        REG_SERIES:    rs_r    <= cfg_ch.wdata[RES_W-1:0];
        REG_NOMINAL:   r0_r    <= cfg_ch.wdata[RES_W-1:0];
        REG_BASE_TEMP: base_r  <= cfg_ch.wdata[BASE_W-1:0];
        REG_BETA0:     beta0_r <= cfg_ch.wdata[BETA0_W-1:0];
        REG_RANGE1:    rng1_r  <= cfg_ch.wdata;
        REG_RANGE2:    rng2_r  <= cfg_ch.wdata;
        default:       ;
      endcase
    end
  end

  // base temperature in centikelvin, split as hi*100 + lo
  assign hi_prod_s = t0c_r * RECIP100_23;
  assign hi100_s   = t0c_hi_r * HUNDRED;
  assign lo_s      = t0c_r - hi100_s;

  always_ff @(posedge clk) begin
    t0c_r    <= {2'b00, base_r} + KELVIN_C;
    t0c_hi_r <= hi_prod_s[RECIP23_S+T0C_HI_W-1:RECIP23_S];
    t0c_lo_r <= lo_s[T0C_LO_W-1:0];
  end

  assign en          = !sv_r;
  assign in_ch.ready = en;

  assign code_n = {1'b0, in_ch.adc_code[ADC_BITS-1:0]};
  assign n_s    = high_r ? (FULL_N - code_n) : code_n;
  assign nc_s   = FULL_N - n_s;

  always_comb begin
    beta_s   = BETA_W'(beta0_r);
    rng_word = '0;
    lhs_s    = CMP_W'(n_s) << LIM_W;
    rhs_s    = '0;
    for (int i = 1; i < BETA_RANGES; i++) begin
      if (i == 1) begin
        rng_word = rng1_r;
      end else if (i == 2) begin
        rng_word = rng2_r;
      end else begin
        rng_word = '0;
      end
      rhs_s = CMP_W'(rng_word[CFG_DATA_W-1:BETA_W]) << ADC_BITS;
      if (lhs_s < rhs_s) begin
        beta_s = rng_word[BETA_W-1:0];
      end
    end
  end

  assign num_full = rs_r * n_s;
  assign den_full = r0_r * nc_s;
  assign hot0_s   = (n_s == '0) || (rs_r == '0);
  assign cold0_s  = !hot0_s && ((n_s == FULL_N) || (r0_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta0_r <= '0;
      for (int k = 0; k < LOG_LAT; k++) begin
        meta_lg_r[k] <= '0;
      end
    end else if (en) begin
      meta0_r.vld  <= in_ch.valid;
      meta0_r.hot  <= hot0_s;
      meta0_r.cold <= cold0_s;
      meta0_r.over <= 1'b0;
      meta0_r.beta <= beta_s;
      meta_lg_r[0] <= meta0_r;
      for (int k = 1; k < LOG_LAT; k++) begin
        meta_lg_r[k] <= meta_lg_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= num_full[NUM_W-1:0];
      den0_r <= den_full[NUM_W-1:0];
    end
  end

  thtc_log2 #(.W(NUM_W), .LW(LOG_W)) u_log_num (
    .clk (clk),
    .en  (en),
    .x   (num0_r),
    .y   (log_n)
  );

  thtc_log2 #(.W(NUM_W), .LW(LOG_W)) u_log_den (
    .clk (clk),
    .en  (en),
    .x   (den0_r),
    .y   (log_d)
  );

  thtc_lnscale #(.LW(LOG_W)) u_lnscale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .meta_i  (meta_lg_r[LOG_LAT-1]),
    .log_n   (log_n),
    .log_d   (log_d),
    .t0c     (t0c_r),
    .t0c_hi  (t0c_hi_r),
    .t0c_lo  (t0c_lo_r),
    .meta_o  (ln_meta),
    .quo_num (ln_num),
    .quo_den (ln_den)
  );

  thtc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .meta_i (ln_meta),
    .num_i  (ln_num),
    .den_i  (ln_den),
    .meta_o (dv_meta),
    .quo_o  (dv_quo)
  );

  assign tc_s = $signed({1'b0, dv_quo}) - $signed({1'b0, KELVIN_C});

  always_comb begin
    if (dv_meta.hot) begin
      fin_temp_s = T_MAX_C;
      fin_oor_s  = 1'b1;
    end else if (dv_meta.cold) begin
      fin_temp_s = T_MIN_C;
      fin_oor_s  = 1'b1;
    end else if (dv_meta.over || (dv_quo > TK_MAX_C)) begin
      fin_temp_s = T_MAX_C;
      fin_oor_s  = 1'b1;
    end else if (tc_s < $signed({T_MIN_C[TEMP_W-1], T_MIN_C})) begin
      fin_temp_s = T_MIN_C;
      fin_oor_s  = 1'b1;
    end else begin
      fin_temp_s = tc_s[TEMP_W-1:0];
      fin_oor_s  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (en) begin
        pv_r <= dv_meta.vld;
      end
      if (en && pv_r && !out_ch.ready) begin
        sv_r <= 1'b1;
      end else if (sv_r && out_ch.ready) begin
        sv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_temp_r <= fin_temp_s;
      fin_oor_r  <= fin_oor_s;
      if (pv_r && !out_ch.ready) begin
        sk_temp_r <= fin_temp_r;
        sk_oor_r  <= fin_oor_r;
      end
    end
  end

  assign out_ch.valid        = pv_r | sv_r;
  assign out_ch.temp_centi   = sv_r ? sk_temp_r : fin_temp_r;
  assign out_ch.out_of_range = sv_r ? sk_oor_r : fin_oor_r;

`ifndef ASSERT_OFF
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sv_r) |-> $past(pv_r && !out_ch.ready))
    else $error("skid filled without a stalled output word");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && !out_ch.ready) |=> (sv_r && $stable(sk_temp_r) && $stable(fin_temp_r)))
    else $error("stalled words not held");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.out_of_range) |->
      (out_ch.temp_centi >= T_MIN_C && out_ch.temp_centi <= T_MAX_C))
    else $error("unsaturated temperature outside range");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |->
      (out_ch.temp_centi == T_MAX_C || out_ch.temp_centi == T_MIN_C))
    else $error("out of range word not at a limit");
`endif

endmodule

[verif/thtc_tb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter result checker
// Watches the configuration, input and result channels, computes the expected
// temperature of every accepted ADC code and compares it with the results.
// ----------------------------------------------------------------------------
module thtc_tb_checker
  import thtc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  thtc_in_if   in_ch,
  thtc_out_if  out_ch,
  thtc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } temp_word_t;

  temp_word_t temps_due[$];

  logic              hi_side;
  logic [RES_W-1:0]  rs;
  logic [RES_W-1:0]  r0;
  logic [BASE_W-1:0] base_c;
  logic [BETA0_W-1:0] beta0;
  logic [27:0]       rng1;
  logic [27:0]       rng2;

  function automatic u64_t log2_fix(u64_t x);
    int p;
    u64_t f;
    int idx;
    u64_t rem;
    u64_t lo;
    u64_t hi;
    p = 0;
    while ((x >> p) > 1) p++;
    f = (x << (63 - p)) << 1;
    idx = int'(f >> 60);
    rem = (f >> 44) & 64'hFFFF;
    lo = log_tab(5'(idx));
    hi = log_tab(5'(idx + 1));
    return (u64_t'(p) << 16) + lo + (((hi - lo) * rem) >> 16);
  endfunction

  function automatic temp_word_t convert_code(logic [11:0] code);
    temp_word_t r;
    u64_t n;
    u64_t b;
    u64_t lim;
    u64_t mag;
    u64_t l24;
    u64_t t0c;
    u64_t tk;
    longint signed l2;
    longint signed ln24;
    longint signed d;
    logic [27:0] w;
    n = hi_side ? 4096 - code : code;
    b = beta0;
    for (int i = 1; i < 3; i++) begin
      w = (i == 1) ? rng1 : rng2;
      lim = w[27:16];
      if (n * 4096 < (lim << 12)) b = w[15:0];
    end
    if (n == 0 || rs == 0) return '{T_MAX_C, 1'b1};
    if (n >= 4096 || r0 == 0) return '{T_MIN_C, 1'b1};
    l2 = longint'(log2_fix(u64_t'(rs) * n))
       - longint'(log2_fix(u64_t'(r0) * (4096 - n)));
    mag = (l2 < 0) ? -l2 : l2;
    l24 = (mag * 45426 + 128) >> 8;
    ln24 = (l2 < 0) ? -longint'(l24) : longint'(l24);
    t0c = u64_t'(base_c) + 27315;
    d = ln24 * longint'(t0c) / 100 + longint'(b << 24);
    if (d <= 0) return '{T_MAX_C, 1'b1};
    tk = (((b * t0c) << 24) + u64_t'(d) / 2) / u64_t'(d);
    if (tk > 57315) return '{T_MAX_C, 1'b1};
    if (longint'(tk) - 27315 < -5500) return '{T_MIN_C, 1'b1};
    r.temp = TEMP_W'(longint'(tk) - 27315);
    r.oor = 1'b0;
    return r;
  endfunction

  assign pending_count = temps_due.size();

  always @(posedge clk) begin
    temp_word_t exp_w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      hi_side <= 1'b0;
      rs <= RS_RST;
      r0 <= R0_RST;
      base_c <= BASE_RST;
      beta0 <= BETA0_RST;
      rng1 <= '0;
      rng2 <= '0;
      fail_count <= 0;
      temps_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) temps_due.push_back(convert_code(in_ch.adc_code));
      if (out_ch.valid && out_ch.ready) begin
        if (temps_due.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          exp_w = temps_due.pop_front();
          if (exp_w.temp !== out_ch.temp_centi) begin
            $error("temp_centi expected %0d actual %0d", exp_w.temp, out_ch.temp_centi);
            errs++;
          end
          if (exp_w.oor !== out_ch.out_of_range) begin
            $error("out_of_range expected %0d actual %0d", exp_w.oor, out_ch.out_of_range);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (thtc_reg_t'(cfg_ch.index))
          REG_HIGH_SIDE: hi_side <= cfg_ch.wdata[0];
          REG_SERIES:    rs <= cfg_ch.wdata[RES_W-1:0];
          REG_NOMINAL:   r0 <= cfg_ch.wdata[RES_W-1:0];
          REG_BASE_TEMP: base_c <= cfg_ch.wdata[BASE_W-1:0];
          REG_BETA0:     beta0 <= cfg_ch.wdata[BETA0_W-1:0];
          REG_RANGE1:    rng1 <= cfg_ch.wdata;
          REG_RANGE2:    rng2 <= cfg_ch.wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

[verif/tb_thermistor_adc_to_temperature_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter testbench
// Runs directed and random ADC codes through several register settings with
// random input gaps and result stalls; the checker compares every result.
// ----------------------------------------------------------------------------
module tb_thermistor_adc_to_temperature_core
  import thtc_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  bit   hold_off = 1'b0;

  thtc_in_if  in_ch ();
  thtc_out_if out_ch ();
  thtc_cfg_if cfg_ch ();

  thermistor_adc_to_temperature_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  thtc_tb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  task automatic write_reg(thtc_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_code(logic [11:0] code, bit gaps);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.adc_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_codes(int count, bit gaps);
    logic [11:0] c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: c = 12'($urandom_range(0, 8));
        1: c = 12'($urandom_range(4087, 4095));
        default: c = 12'($urandom);
      endcase
      send_code(c, gaps);
    end
  endtask

  task automatic random_setting();
    write_reg(REG_HIGH_SIDE, 28'($urandom_range(0, 1)));
    write_reg(REG_SERIES, ($urandom_range(0, 4) == 0) ? 28'(1 << $urandom_range(0, 19))
                                                     : 28'($urandom_range(1, 1000000)));
    write_reg(REG_NOMINAL, ($urandom_range(0, 4) == 0) ? 28'(1 << $urandom_range(0, 19))
                                                      : 28'($urandom_range(1, 1000000)));
    write_reg(REG_BASE_TEMP, 28'($urandom_range(0, 15000)));
    write_reg(REG_BETA0, 28'($urandom_range(1000, 10000)));
    write_reg(REG_RANGE1, {12'($urandom_range(0, 4095)), 16'($urandom)});
    write_reg(REG_RANGE2, ($urandom_range(0, 3) == 0) ? 28'($urandom)
                                                     : {12'($urandom), 16'($urandom_range(1000, 10000))});
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_code = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, extremes and each bit
    send_code(12'd0, 0);
    send_code(12'd4095, 0);
    send_code(12'd1, 0);
    send_code(12'd2048, 0);
    for (int b = 0; b < 12; b++) send_code(12'(1 << b), 0);
    send_code(12'hAAA, 0);
    send_code(12'h555, 0);
    drain();

    // high side, zero resistors, ranges and zero B
    write_reg(REG_HIGH_SIDE, 28'd1);
    write_reg(REG_RANGE1, {12'd2048, 16'd4000});
    write_reg(REG_RANGE2, {12'd1024, 16'd0});
    send_code(12'd0, 0);
    send_code(12'd4095, 0);
    send_code(12'd1000, 0);
    send_code(12'd3500, 0);
    drain();
    write_reg(REG_SERIES, 28'd0);
    write_reg(REG_NOMINAL, 28'd0);
    send_code(12'd100, 0);
    drain();
    write_reg(REG_SERIES, 28'd1000000);
    send_code(12'd100, 0);
    drain();
    write_reg(REG_NOMINAL, 28'd1);
    write_reg(REG_BASE_TEMP, 28'd15000);
    write_reg(REG_BETA0, 28'd1000);
    write_reg(REG_RANGE1, 28'hFFFFFFF);
    write_reg(REG_RANGE2, 28'h0);
    send_code(12'd5, 0);
    send_code(12'd4000, 0);
    drain();
    write_reg(REG_HIGH_SIDE, 28'd0);
    write_reg(REG_SERIES, 28'd1);
    write_reg(REG_NOMINAL, 28'd1000000);
    write_reg(REG_BASE_TEMP, 28'd0);
    write_reg(REG_BETA0, 28'd10000);
    write_reg(REG_RANGE1, 28'h0);
    send_code(12'd5, 0);
    send_code(12'd4000, 0);
    drain();

    // receiver held off while codes keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_codes(80, 0);
    join
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_setting();
      random_codes(100, ph % 3 != 2);
      drain();
    end
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
